@@ hdl/rpd_pkg.sv @@
package rpd_pkg;

  localparam int QUEUE_DEPTH_DEF  = 16;
  localparam int MAX_TECHS_DEF    = 8;
  localparam int NUM_MACHINES_DEF = 16;
  localparam int MAX_OUT          = 8;
  localparam int TECHS_W          = 6;
  localparam int CFG_IDX_W        = 4;

  localparam logic [1:0] REQ_FAULT    = 2'd0;
  localparam logic [1:0] REQ_DISPATCH = 2'd1;
  localparam logic [1:0] REQ_CLEAR    = 2'd2;

  localparam logic [1:0] KIND_OK     = 2'd0;
  localparam logic [1:0] KIND_FULL   = 2'd1;
  localparam logic [1:0] KIND_ASSIGN = 2'd2;
  localparam logic [1:0] KIND_NONE   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_PRIO_TABLE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TECH_COUNT = 4'd1;

  typedef enum logic [2:0] {
    OP_FAULT,
    OP_DISPATCH,
    OP_CLEAR,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [3:0]         machine;
    logic [3:0]         prio;
    logic [31:0]        tick;
    logic [7:0]         idle;
    logic [15:0]        broken;
    logic [TECHS_W-1:0] techs;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] tech;
    logic [3:0] machine;
    logic [4:0] count;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [3:0]  machine;
    logic [3:0]  prio;
    logic [31:0] tick;
    logic [31:0] seq;
  } entry_t;

endpackage

@@ hdl/rpd_fifo.sv @@
module rpd_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  logic [WIDTH-1:0] mem_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (do_push) wptr_r <= ~wptr_r;
      if (do_pop) rptr_r <= ~rptr_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

@@ hdl/rpd_front.sv @@
module rpd_front #(
  parameter int MAX_TECHS    = rpd_pkg::MAX_TECHS_DEF,
  parameter int NUM_MACHINES = rpd_pkg::NUM_MACHINES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  input  logic [rpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [63:0]                    cfg_data,
  input  logic [1:0]                     req_type,
  input  logic [3:0]                     machine_id,
  input  logic [3:0]                     machine_type,
  input  logic [31:0]                    fault_tick,
  input  logic [7:0]                     idle_mask,
  input  logic [15:0]                    broken_mask,
  output rpd_pkg::cmd_t                  cmd
);
  import rpd_pkg::*;

  logic [63:0] prio_table_r;
  logic [3:0]  tech_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prio_table_r <= '1;
      tech_count_r <= 4'd8;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_PRIO_TABLE) prio_table_r <= cfg_data;
      else if (cfg_index == CFG_TECH_COUNT) tech_count_r <= cfg_data[3:0];
    end
  end

  always_comb begin
    cmd.machine = machine_id;
    cmd.prio    = prio_table_r[{machine_type, 2'b00} +: 4];
    cmd.tick    = fault_tick;
    cmd.idle    = idle_mask;
    cmd.broken  = broken_mask;
    if (32'(tech_count_r) > MAX_TECHS) cmd.techs = TECHS_W'(MAX_TECHS);
    else cmd.techs = TECHS_W'(tech_count_r);
    case (req_type)
      REQ_FAULT:    cmd.op = (32'(machine_id) >= NUM_MACHINES) ? OP_NOP : OP_FAULT;
      REQ_DISPATCH: cmd.op = OP_DISPATCH;
      REQ_CLEAR:    cmd.op = OP_CLEAR;
      default:      cmd.op = OP_NOP;
    endcase
  end

endmodule

@@ hdl/rpd_back.sv @@
module rpd_back #(
  parameter int QUEUE_DEPTH = rpd_pkg::QUEUE_DEPTH_DEF,
  parameter int MAX_TECHS   = rpd_pkg::MAX_TECHS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  rpd_pkg::cmd_t cmd,
  input  logic          cmd_empty,
  output logic          cmd_pop,
  output rpd_pkg::res_t res,
  output logic          res_push,
  input  logic          res_full
);
  import rpd_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int TW = $clog2(MAX_TECHS + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DISP = 2'b10
  } state_t;

  state_t          state_r, state_nxt;
  entry_t          ent_r [QUEUE_DEPTH];
  entry_t          ent_nxt [QUEUE_DEPTH];
  logic [CW-1:0]   count_r, count_nxt;
  logic [31:0]     seq_r, seq_nxt;
  logic [TW-1:0]   t_r, t_nxt;
  logic [3:0]      n_r, n_nxt;
  logic [7:0]      idle_r;
  logic [15:0]     broken_r;
  logic [TECHS_W-1:0] techs_r;
  res_t            pend_r, pend_nxt;
  logic            pend_v_r, pend_v_nxt;
  logic            load_disp;
  logic [QUEUE_DEPTH-1:0] keep;
  entry_t          new_ent;
  logic            idle_bit;

  assign new_ent = '{machine: cmd.machine, prio: cmd.prio, tick: cmd.tick, seq: seq_r};
  assign idle_bit = (32'(t_r) < 8) && idle_r[3'(t_r)];

  // slot stays in place when it sorts at or ahead of the new key
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (32'(i) >= 32'(count_r)) keep[i] = 1'b0;
      else if (ent_r[i].prio != new_ent.prio) keep[i] = ent_r[i].prio < new_ent.prio;
      else if (ent_r[i].tick != new_ent.tick) keep[i] = ent_r[i].tick < new_ent.tick;
      else keep[i] = ent_r[i].seq <= new_ent.seq;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    ent_nxt    = ent_r;
    count_nxt  = count_r;
    seq_nxt    = seq_r;
    t_nxt      = t_r;
    n_nxt      = n_r;
    pend_nxt   = pend_r;
    pend_v_nxt = pend_v_r;
    cmd_pop    = 1'b0;
    res_push   = 1'b0;
    load_disp  = 1'b0;
    res        = '{kind: KIND_OK, tech: 3'd0, machine: 4'd0, count: 5'(count_r), last: 1'b1};
    case (state_r)
      ST_IDLE: begin
        if (!cmd_empty && !res_full) begin
          cmd_pop = 1'b1;
          case (cmd.op)
            OP_FAULT: begin
              res_push = 1'b1;
              if (32'(count_r) >= QUEUE_DEPTH) begin
                res.kind = KIND_FULL;
              end else begin
                for (int i = 0; i < QUEUE_DEPTH; i++) begin
                  if (keep[i]) ent_nxt[i] = ent_r[i];
                  else if (i == 0) ent_nxt[i] = new_ent;
                  else if (keep[i-1]) ent_nxt[i] = new_ent;
                  else ent_nxt[i] = ent_r[i-1];
                end
                count_nxt = count_r + CW'(1);
                seq_nxt   = seq_r + 32'd1;
                res.count = 5'(count_r + CW'(1));
              end
            end
            OP_DISPATCH: begin
              load_disp  = 1'b1;
              t_nxt      = '0;
              n_nxt      = '0;
              pend_v_nxt = 1'b0;
              state_nxt  = ST_DISP;
            end
            OP_CLEAR: begin
              res_push  = 1'b1;
              count_nxt = '0;
              seq_nxt   = '0;
              res.count = 5'd0;
            end
            default: res_push = 1'b1;
          endcase
        end
      end
      ST_DISP: begin
        if (32'(t_r) >= 32'(techs_r) || count_r == '0) begin
          if (!res_full) begin
            res_push = 1'b1;
            if (pend_v_r) begin
              res      = pend_r;
              res.last = 1'b1;
            end else begin
              res.kind = KIND_NONE;
            end
            state_nxt = ST_IDLE;
          end
        end else if (!broken_r[ent_r[0].machine]) begin
          for (int i = 0; i < QUEUE_DEPTH - 1; i++) ent_nxt[i] = ent_r[i+1];
          count_nxt = count_r - CW'(1);
        end else if (!idle_bit || 32'(n_r) >= MAX_OUT) begin
          t_nxt = t_r + TW'(1);
        end else if (!res_full) begin
          for (int i = 0; i < QUEUE_DEPTH - 1; i++) ent_nxt[i] = ent_r[i+1];
          count_nxt = count_r - CW'(1);
          if (pend_v_r) begin
            res_push = 1'b1;
            res      = pend_r;
            res.last = 1'b0;
          end
          pend_nxt   = '{kind: KIND_ASSIGN, tech: 3'(t_r), machine: ent_r[0].machine,
                         count: 5'(count_r - CW'(1)), last: 1'b0};
          pend_v_nxt = 1'b1;
          n_nxt      = n_r + 4'd1;
          t_nxt      = t_r + TW'(1);
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    ent_r  <= ent_nxt;
    pend_r <= pend_nxt;
    t_r    <= t_nxt;
    n_r    <= n_nxt;
    if (load_disp) begin
      idle_r   <= cmd.idle;
      broken_r <= cmd.broken;
      techs_r  <= cmd.techs;
    end
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      count_r  <= '0;
      seq_r    <= '0;
      pend_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      seq_r    <= seq_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

endmodule

@@ hdl/repair_priority_dispatcher.sv @@
// Repair dispatcher: fault reports are inserted into a sorted queue (priority from
// prio_table by machine type, then fault tick, then arrival), dispatch ticks hand
// head entries to idle technicians, clear empties the queue. Requests pass through a
// two-entry command queue, so full is raised only when two are already waiting. A fault,
// clear or unused request is handled in the IDLE state and gives one result. A dispatch
// enters the DISP state, where the sequencer walks one technician or drops one head
// entry per cycle, stalling when a result must be pushed into a full output queue; at
// most 8 assignments are reported, the last result of each request has last set.
// Results wait in a two-entry output queue; a full one stalls the back end.
module repair_priority_dispatcher #(
  parameter int QUEUE_DEPTH  = rpd_pkg::QUEUE_DEPTH_DEF,
  parameter int MAX_TECHS    = rpd_pkg::MAX_TECHS_DEF,
  parameter int NUM_MACHINES = rpd_pkg::NUM_MACHINES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                   cfg_data,
  input  logic                          push,
  output logic                          full,
  input  logic [1:0]                    in_req_type,
  input  logic [3:0]                    in_machine_id,
  input  logic [3:0]                    in_machine_type,
  input  logic [31:0]                   in_fault_tick,
  input  logic [7:0]                    in_idle_mask,
  input  logic [15:0]                   in_broken_mask,
  output logic                          empty,
  input  logic                          pop,
  output logic [1:0]                    out_kind,
  output logic [2:0]                    out_tech_index,
  output logic [3:0]                    out_assigned_machine,
  output logic [4:0]                    out_queue_count,
  output logic                          out_last
);
  import rpd_pkg::*;

  cmd_t cmd_in, cmd_out;
  res_t res_in, res_out;
  logic cmd_empty, cmd_pop, res_push, res_full;

  assign cfg_ready = 1'b1;

  rpd_front #(.MAX_TECHS(MAX_TECHS), .NUM_MACHINES(NUM_MACHINES)) u_front (
    .clk, .rst_n, .cfg_valid, .cfg_index, .cfg_data,
    .req_type(in_req_type), .machine_id(in_machine_id), .machine_type(in_machine_type),
    .fault_tick(in_fault_tick), .idle_mask(in_idle_mask), .broken_mask(in_broken_mask),
    .cmd(cmd_in)
  );

  rpd_fifo #(.WIDTH($bits(cmd_t))) u_cmd_q (
    .clk, .rst_n, .push(push), .wdata(cmd_in), .full(full),
    .pop(cmd_pop), .rdata(cmd_out), .empty(cmd_empty)
  );

  rpd_back #(.QUEUE_DEPTH(QUEUE_DEPTH), .MAX_TECHS(MAX_TECHS)) u_back (
    .clk, .rst_n, .cmd(cmd_out), .cmd_empty, .cmd_pop,
    .res(res_in), .res_push, .res_full
  );

  rpd_fifo #(.WIDTH($bits(res_t))) u_res_q (
    .clk, .rst_n, .push(res_push), .wdata(res_in), .full(res_full),
    .pop(pop), .rdata(res_out), .empty(empty)
  );

  assign out_kind             = res_out.kind;
  assign out_tech_index       = res_out.tech;
  assign out_assigned_machine = res_out.machine;
  assign out_queue_count      = res_out.count;
  assign out_last             = res_out.last;

endmodule

@@ hdl/rpd_checker.sv @@
module rpd_checker #(
  parameter int QUEUE_DEPTH = rpd_pkg::QUEUE_DEPTH_DEF
) (
  input logic       clk,
  input logic       rst_n,
  input logic       empty,
  input logic       pop,
  input logic [1:0] out_kind,
  input logic [2:0] out_tech_index,
  input logic [3:0] out_assigned_machine,
  input logic [4:0] out_queue_count,
  input logic       out_last
);
  import rpd_pkg::*;

  a_non_assign_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_kind != KIND_ASSIGN) |-> (out_tech_index == 3'd0 &&
      out_assigned_machine == 4'd0))
    else $error("non-assignment result carries technician or machine");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && QUEUE_DEPTH < 32) |-> (32'(out_queue_count) <= QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_kind == KIND_FULL && QUEUE_DEPTH < 32) |->
      (32'(out_queue_count) == QUEUE_DEPTH))
    else $error("queue full drop with queue not full");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_kind == KIND_OK || out_kind == KIND_FULL || out_kind == KIND_NONE))
      |-> out_last)
    else $error("single result without last");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_kind) && $stable(out_queue_count)))
    else $error("waiting result changed");

endmodule

bind repair_priority_dispatcher rpd_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_rpd_checker (
  .clk, .rst_n, .empty, .pop, .out_kind, .out_tech_index, .out_assigned_machine,
  .out_queue_count, .out_last
);

@@ tb/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rpd_pkg::*;

  localparam int DEPTH = 16;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 4'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic push = 1'b0;
  logic full;
  logic [1:0] in_req_type = '0;
  logic [3:0] in_machine_id = '0;
  logic [3:0] in_machine_type = '0;
  logic [31:0] in_fault_tick = '0;
  logic [7:0] in_idle_mask = '0;
  logic [15:0] in_broken_mask = '0;
  logic empty;
  logic pop = 1'b0;
  logic [1:0] out_kind;
  logic [2:0] out_tech_index;
  logic [3:0] out_assigned_machine;
  logic [4:0] out_queue_count;
  logic out_last;

  repair_priority_dispatcher DUT (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  // predictor state
  logic [63:0] prio_map;
  logic [3:0] techs_cfg;
  entry_t repair_q[$];
  logic [31:0] seq_next;
  res_t expected_res[$];

  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_assigned = 0;
  int n_full = 0;
  bit hold_pop = 1'b0;
  bit pop_random = 1'b1;

  function automatic void add_result(logic [1:0] k, logic [2:0] t, logic [3:0] m);
    res_t r;
    r.kind = k;
    r.tech = t;
    r.machine = m;
    r.count = 5'(repair_q.size());
    r.last = 1'b0;
    expected_res.insert(expected_res.size(), r);
  endfunction

  function automatic void predict_request(logic [1:0] rq, logic [3:0] mid, logic [3:0] mt,
                                          logic [31:0] tk, logic [7:0] idle,
                                          logic [15:0] broken);
    entry_t e;
    int pos;
    int techs;
    int nres;
    nres = 0;
    case (rq)
      REQ_FAULT: begin
        if (repair_q.size() >= DEPTH) begin
          add_result(KIND_FULL, 3'd0, 4'd0);
        end else begin
          e.machine = mid;
          e.prio = prio_map[4*mt +: 4];
          e.tick = tk;
          e.seq = seq_next;
          pos = repair_q.size();
          // new entry goes after every entry with key <= its own
          while (pos > 0 && !(repair_q[pos-1].prio < e.prio ||
                 (repair_q[pos-1].prio == e.prio && (repair_q[pos-1].tick < e.tick ||
                 (repair_q[pos-1].tick == e.tick && repair_q[pos-1].seq <= e.seq)))))
            pos--;
          repair_q.insert(pos, e);
          seq_next++;
          add_result(KIND_OK, 3'd0, 4'd0);
        end
      end
      REQ_DISPATCH: begin
        techs = (techs_cfg > 8) ? 8 : techs_cfg;
        for (int t = 0; t < techs; t++) begin
          while (repair_q.size() > 0 && !broken[repair_q[0].machine])
            void'(repair_q.pop_front());
          if (repair_q.size() == 0) break;
          if (!idle[t]) continue;
          e = repair_q.pop_front();
          add_result(KIND_ASSIGN, 3'(t), e.machine);
          nres++;
        end
        if (nres == 0) add_result(KIND_NONE, 3'd0, 4'd0);
      end
      REQ_CLEAR: begin
        repair_q.delete();
        seq_next = '0;
        add_result(KIND_OK, 3'd0, 4'd0);
      end
      default: add_result(KIND_OK, 3'd0, 4'd0);
    endcase
    expected_res[$].last = 1'b1;
  endfunction

  task automatic send_request(logic [1:0] rq, logic [3:0] mid, logic [3:0] mt,
                              logic [31:0] tk, logic [7:0] idle, logic [15:0] broken);
    push <= 1'b1;
    in_req_type <= rq;
    in_machine_id <= mid;
    in_machine_type <= mt;
    in_fault_tick <= tk;
    in_idle_mask <= idle;
    in_broken_mask <= broken;
    do @(posedge clk); while (full);
    predict_request(rq, mid, mt, tk, idle, broken);
    n_sent++;
    @(negedge clk);
    push <= 1'b0;
    @(negedge clk);
  endtask

  // bursts with random gaps; push stays high across back-to-back items
  task automatic send_random(int count, int fault_pct, int dispatch_pct);
    int burst;
    int r;
    logic [1:0] rq;
    burst = 0;
    for (int i = 0; i < count; i++) begin
      if (burst == 0) begin
        repeat ($urandom_range(1, 6)) @(negedge clk);
        burst = $urandom_range(1, 8);
      end
      burst--;
      r = $urandom_range(0, 99);
      if (r < fault_pct) rq = REQ_FAULT;
      else if (r < fault_pct + dispatch_pct) rq = REQ_DISPATCH;
      else if (r < 98) rq = REQ_CLEAR;
      else rq = REQ_UNUSED;
      push <= 1'b1;
      in_req_type <= rq;
      in_machine_id <= 4'($urandom);
      in_machine_type <= 4'($urandom);
      in_fault_tick <= ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 7);
      in_idle_mask <= 8'($urandom);
      in_broken_mask <= ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'hffff;
      do @(posedge clk); while (full);
      predict_request(rq, in_machine_id, in_machine_type, in_fault_tick, in_idle_mask,
                      in_broken_mask);
      n_sent++;
      @(negedge clk);
      if (burst == 0 || i == count - 1) push <= 1'b0;
    end
  endtask

  task automatic wait_idle();
    int guard;
    guard = 0;
    while (expected_res.size() > 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_PRIO_TABLE) prio_map = val;
    else if (idx == CFG_TECH_COUNT) techs_cfg = val[3:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    res_t exp_r;
    if (rst_n && pop && !empty) begin
      n_checked++;
      if (expected_res.size() == 0) begin
        $error("unexpected result kind=%0d", out_kind);
        errors++;
      end else begin
        exp_r = expected_res.pop_front();
        if (out_kind == KIND_ASSIGN) n_assigned++;
        if (out_kind == KIND_FULL) n_full++;
        if (out_kind !== exp_r.kind) begin
          $error("kind exp %0d got %0d", exp_r.kind, out_kind); errors++;
        end
        if (out_tech_index !== exp_r.tech) begin
          $error("tech_index exp %0d got %0d", exp_r.tech, out_tech_index); errors++;
        end
        if (out_assigned_machine !== exp_r.machine) begin
          $error("assigned_machine exp %0d got %0d", exp_r.machine, out_assigned_machine);
          errors++;
        end
        if (out_queue_count !== exp_r.count) begin
          $error("queue_count exp %0d got %0d", exp_r.count, out_queue_count); errors++;
        end
        if (out_last !== exp_r.last) begin
          $error("last exp %0d got %0d", exp_r.last, out_last); errors++;
        end
      end
    end
  end

  // receiver stall pattern, with a stretch of no stalls and a long hold-off
  always @(negedge clk) begin
    if (hold_pop) pop <= 1'b0;
    else if (!pop_random) pop <= 1'b1;
    else pop <= ($urandom_range(0, 3) != 0);
  end

  task automatic test_directed_faults();
    send_request(REQ_FAULT, 4'd3, 4'd0, 32'd10, 8'h00, 16'h0000);
    send_request(REQ_FAULT, 4'd15, 4'd15, 32'hffffffff, 8'hff, 16'hffff);
    send_request(REQ_FAULT, 4'd0, 4'd1, 32'd0, 8'h00, 16'h0000);
    send_request(REQ_FAULT, 4'd7, 4'd0, 32'd10, 8'h00, 16'h0000);
    send_request(REQ_FAULT, 4'd9, 4'd2, 32'd5, 8'h00, 16'h0000);
    send_request(REQ_UNUSED, 4'd1, 4'd1, 32'd1, 8'h55, 16'haaaa);
    // busy techs skipped; machine 7 is marked stale but never reaches the head to be dropped
    send_request(REQ_DISPATCH, 4'd0, 4'd0, 32'd0, 8'b1010_0000, 16'hff7f);
    send_request(REQ_DISPATCH, 4'd0, 4'd0, 32'd0, 8'h00, 16'hffff);
    send_request(REQ_DISPATCH, 4'd0, 4'd0, 32'd0, 8'hff, 16'hffff);
    send_request(REQ_DISPATCH, 4'd0, 4'd0, 32'd0, 8'hff, 16'hffff);
    for (int i = 0; i < 18; i++)
      send_request(REQ_FAULT, 4'(i), 4'(i), 32'(i % 3), 8'h00, 16'h0000);
    send_request(REQ_DISPATCH, 4'd0, 4'd0, 32'd0, 8'hff, 16'h0000);
    send_request(REQ_CLEAR, 4'd0, 4'd0, 32'd0, 8'h00, 16'h0000);
    wait_idle();
  endtask

  task automatic test_config_sweep();
    logic [63:0] tbl;
    for (int ph = 0; ph < 6; ph++) begin
      tbl = {$urandom, $urandom};
      if (ph == 0) tbl = '0;
      if (ph == 1) tbl = 64'hfedcba9876543210;
      write_reg(CFG_PRIO_TABLE, tbl);
      write_reg(CFG_TECH_COUNT, (ph == 0) ? 64'd1 : (ph == 1) ? 64'd8 :
                (ph == 2) ? 64'd15 : (ph == 3) ? 64'd0 : 64'($urandom_range(1, 8)));
      if (ph == 4) write_reg(CFG_UNUSED_IDX, 64'hdeadbeef);
      send_random(30, 55, 35);
      wait_idle();
    end
  endtask

  task automatic test_backpressure();
    int cnt;
    hold_pop = 1'b1;
    fork
      begin
        cnt = 0;
        while (cnt < 300) begin
          @(posedge clk);
          cnt++;
        end
        hold_pop = 1'b0;
      end
      send_random(40, 70, 25);
    join
    wait_idle();
  endtask

  initial begin
    prio_map = '1;
    techs_cfg = 4'd8;
    seq_next = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed_faults();
    pop_random = 1'b0;
    test_config_sweep();
    pop_random = 1'b1;
    test_backpressure();
    repeat (50) @(negedge clk);
    $display("summary: %0d requests sent, %0d results checked", n_sent, n_checked);
    $display("summary: %0d assignments, %0d queue-full drops", n_assigned, n_full);
    if (errors == 0 && expected_res.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      if (expected_res.size() != 0) $error("%0d results never arrived", expected_res.size());
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("testbench: done, errors");
    $finish;
  end
endmodule

@@ files.f @@
hdl/rpd_pkg.sv
hdl/rpd_fifo.sv
hdl/rpd_front.sv
hdl/rpd_back.sv
hdl/repair_priority_dispatcher.sv
hdl/rpd_checker.sv
tb/testbench.sv
